FILE: hw/rtl/stpseq_pkg.sv
// Package for the stepper step sequencer: field widths, command and run-state codes,
// register indexes, result struct and the coil pattern table.
// No dependencies.
package stpseq_pkg;

    // Field and state widths
    localparam int POSITION_BITS = 32;
    localparam int INTERVAL_BITS = 24;
    localparam int COUNT_BITS    = 32;
    localparam int COMMAND_BITS  = 3;
    localparam int COIL_BITS     = 4;
    localparam int RUN_BITS      = 2;
    localparam int PHASE_BITS    = 2;
    localparam int CFG_IDX_BITS  = 2;

    // Stream payload widths, whole bytes
    localparam int IN_FIELD_BITS  = COMMAND_BITS + COUNT_BITS + 1;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = COIL_BITS + POSITION_BITS + RUN_BITS + 1;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [COMMAND_BITS-1:0] {
        CMD_TICK       = 3'd0,
        CMD_MOVE_REL   = 3'd1,
        CMD_MOVE_CONT  = 3'd2,
        CMD_STOP       = 3'd3,
        CMD_PAUSE      = 3'd4,
        CMD_RESUME     = 3'd5
    } command_t;

    typedef enum logic [RUN_BITS-1:0] {
        RUN_STOPPED = 2'd0,
        RUN_MOVING  = 2'd1,
        RUN_PAUSED  = 2'd2
    } run_state_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_INTERVAL    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_CORRECTION = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_MODE       = 2'd2;

    // Phase modes; bit 1 set means half-step (mode three acts as half-step)
    localparam logic [PHASE_BITS-1:0] PHASE_WAVE = 2'd0;
    localparam logic [PHASE_BITS-1:0] PHASE_FULL = 2'd1;
    localparam logic [PHASE_BITS-1:0] PHASE_HALF = 2'd2;

    typedef struct packed {
        logic                     wr;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [INTERVAL_BITS-1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic                     stepped;
        run_state_t               run_state;
        logic [POSITION_BITS-1:0] position;
        logic [COIL_BITS-1:0]     coil_pattern;
    } result_t;

    // Coil table: wave group in entries 0..3, full group in entries 4..7
    localparam logic [COIL_BITS-1:0] COIL_TABLE [8] = '{
        4'b0001, 4'b0010, 4'b0100, 4'b1000,
        4'b0011, 4'b0110, 4'b1100, 4'b1001
    };

    function automatic logic [COIL_BITS-1:0] coil_lookup(
        input logic       group,
        input logic [1:0] idx
    );
        return COIL_TABLE[{group, idx}];
    endfunction

endpackage

FILE: hw/rtl/stpseq_core.sv
// Sequencer state and per-item update: position, target, timer, run state, coils,
// plus the configuration registers. Next result is presented combinationally.
// Depends on stpseq_pkg.
module stpseq_core
    import stpseq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_write_t               cfg,
    input  logic                     item_fire,
    input  logic [COMMAND_BITS-1:0]  command,
    input  logic [COUNT_BITS-1:0]    step_count,
    input  logic                     direction,
    output result_t                  result
);

    // Configuration registers
    logic [INTERVAL_BITS-1:0] step_interval_reg;
    logic [INTERVAL_BITS-1:0] delay_correction_reg;
    logic [PHASE_BITS-1:0]    phase_mode_reg;

    // Motion state
    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic [POSITION_BITS-1:0] target_reg, target_next;
    logic                     dir_reg, dir_next;
    logic                     cont_reg, cont_next;
    run_state_t               state_reg, state_next;
    logic [INTERVAL_BITS-1:0] tick_reg, tick_next;
    logic                     stop_reg, stop_next;
    logic [COIL_BITS-1:0]     coil_reg, coil_next;
    logic                     stepped;

    // Step period: interval minus correction, floor 1, halved in half-step
    logic [INTERVAL_BITS-1:0] diff;
    logic [INTERVAL_BITS-1:0] base_period;
    logic [INTERVAL_BITS-1:0] period;
    logic                     half_mode;

    assign half_mode   = phase_mode_reg[1];
    assign diff        = step_interval_reg - delay_correction_reg;
    assign base_period = (step_interval_reg > delay_correction_reg)
                         ? diff : INTERVAL_BITS'(1);

    always_comb
    begin
        period = base_period;
        if (half_mode)
        begin
            period = base_period >> 1;
            if (period == '0)
                period = INTERVAL_BITS'(1);
        end
    end

    // Timer expiry and the next position for a step
    logic [INTERVAL_BITS-1:0] tick_inc;
    logic                     expire;
    logic [POSITION_BITS-1:0] step_pos;
    logic                     coil_group;
    logic [1:0]               coil_idx;

    assign tick_inc = tick_reg + INTERVAL_BITS'(1);
    assign expire   = (tick_inc >= period);
    assign step_pos = dir_reg ? (position_reg - POSITION_BITS'(1))
                              : (position_reg + POSITION_BITS'(1));

    always_comb
    begin
        if (half_mode)
        begin
            coil_group = step_pos[0];
            coil_idx   = step_pos[2:1];
        end
        else
        begin
            coil_group = phase_mode_reg[0];
            coil_idx   = step_pos[1:0];
        end
    end

    // Per-item update
    always_comb
    begin
        position_next = position_reg;
        target_next   = target_reg;
        dir_next      = dir_reg;
        cont_next     = cont_reg;
        state_next    = state_reg;
        tick_next     = tick_reg;
        stop_next     = stop_reg;
        coil_next     = coil_reg;
        stepped       = 1'b0;

        case (command_t'(command))
            CMD_TICK:
            begin
                if (state_reg == RUN_MOVING)
                begin
                    tick_next = tick_inc;
                    if (expire)
                    begin
                        tick_next = '0;
                        if (stop_reg || (!cont_reg && position_reg == target_reg))
                        begin
                            // end of run
                            state_next = RUN_STOPPED;
                            coil_next  = '0;
                            cont_next  = 1'b0;
                            stop_next  = 1'b0;
                        end
                        else
                        begin
                            position_next = step_pos;
                            coil_next     = coil_lookup(coil_group, coil_idx);
                            stepped       = 1'b1;
                        end
                    end
                end
            end
            CMD_MOVE_REL:
            begin
                if (state_reg == RUN_STOPPED && step_count != '0 &&
                    step_interval_reg != '0)
                begin
                    target_next = position_reg + step_count[POSITION_BITS-1:0];
                    dir_next    = step_count[COUNT_BITS-1];
                    cont_next   = 1'b0;
                    stop_next   = 1'b0;
                    tick_next   = '0;
                    state_next  = RUN_MOVING;
                end
            end
            CMD_MOVE_CONT:
            begin
                if (state_reg == RUN_STOPPED && step_interval_reg != '0)
                begin
                    dir_next   = direction;
                    cont_next  = 1'b1;
                    stop_next  = 1'b0;
                    tick_next  = '0;
                    state_next = RUN_MOVING;
                end
            end
            CMD_STOP:
            begin
                if (state_reg != RUN_STOPPED)
                    stop_next = 1'b1;
            end
            CMD_PAUSE:
            begin
                if (state_reg == RUN_MOVING)
                    state_next = RUN_PAUSED;
            end
            CMD_RESUME:
            begin
                if (state_reg == RUN_PAUSED)
                    state_next = RUN_MOVING;
            end
            default:
            begin
            end
        endcase
    end

    assign result.stepped      = stepped;
    assign result.run_state    = state_next;
    assign result.position     = position_next;
    assign result.coil_pattern = coil_next;

    // Configuration registers; interval and phase only take writes while stopped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_interval_reg    <= '0;
            delay_correction_reg <= '0;
            phase_mode_reg       <= PHASE_FULL;
        end
        else if (cfg.wr)
        begin
            case (cfg.index)
                CFG_STEP_INTERVAL:
                begin
                    if (state_reg == RUN_STOPPED)
                        step_interval_reg <= cfg.data;
                end
                CFG_DELAY_CORRECTION:
                begin
                    delay_correction_reg <= cfg.data;
                end
                CFG_PHASE_MODE:
                begin
                    if (state_reg == RUN_STOPPED)
                        phase_mode_reg <= cfg.data[PHASE_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Motion state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            target_reg   <= '0;
            dir_reg      <= 1'b0;
            cont_reg     <= 1'b0;
            state_reg    <= RUN_STOPPED;
            tick_reg     <= '0;
            stop_reg     <= 1'b0;
            coil_reg     <= '0;
        end
        else if (item_fire)
        begin
            position_reg <= position_next;
            target_reg   <= target_next;
            dir_reg      <= dir_next;
            cont_reg     <= cont_next;
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            stop_reg     <= stop_next;
            coil_reg     <= coil_next;
        end
    end

endmodule

FILE: hw/rtl/stepper_step_sequencer_core.sv
// Four-coil stepper step sequencer, top level.
// Input register, then result register; the state update is one pass between the two.
// Throughput: one item per cycle unless the result stream stalls (m_axis_tready low).
// Reset (rst_n low, async): stopped, position 0, coils off, phase mode full, interval 0.
// Depends on stpseq_pkg and stpseq_core.
module stepper_step_sequencer_core
    import stpseq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [2:0] command, [34:3] step_count, [35] direction, [39:36] zero
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // Result stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [3:0] coil_pattern, [35:4] position, [37:36] run_state, [38] stepped, [39] zero
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // Configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [INTERVAL_BITS-1:0] cfg_data
);

    logic                     in_valid_reg;
    logic [IN_FIELD_BITS-1:0] in_data_reg;
    logic                     out_valid_reg;
    result_t                  out_data_reg;
    logic                     advance;
    result_t                  result;
    cfg_write_t               cfg;

    // Item moves into the result register when that register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign cfg_ready = 1'b1;
    assign cfg.wr    = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_data_reg <= s_axis_tdata[IN_FIELD_BITS-1:0];
    end

    stpseq_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_fire  (advance),
        .command    (in_data_reg[COMMAND_BITS-1:0]),
        .step_count (in_data_reg[COMMAND_BITS +: COUNT_BITS]),
        .direction  (in_data_reg[IN_FIELD_BITS-1]),
        .result     (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}},
                            out_data_reg.stepped,
                            out_data_reg.run_state,
                            out_data_reg.position,
                            out_data_reg.coil_pattern};

endmodule

FILE: hw/rtl/stpseq_checker.sv
// Port-level checks for the stepper step sequencer, bound to the top level.
// Depends on stpseq_pkg and stepper_step_sequencer_core.
module stpseq_checker
    import stpseq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    // No result shown in the cycle after reset is seen at an edge
    a_no_valid_in_reset: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // Stalled result keeps its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A step only happens in a moving run
    a_step_moving: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[38]) |-> (m_axis_tdata[37:36] == RUN_MOVING))
        else $error("step reported outside a moving run");

    // Coils are off whenever the motor is stopped
    a_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[37:36] == RUN_STOPPED) |-> (m_axis_tdata[3:0] == '0))
        else $error("coils driven while stopped");

endmodule

bind stepper_step_sequencer_core stpseq_checker u_stpseq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
